>>> rtl/rlpd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rlpd_pkg: shared types and codes for the priority dispatcher
// Function codes, result status codes and reject causes.
// ----------------------------------------------------------------------------
package rlpd_pkg;

   typedef enum logic [2:0] {
      FUNC_SUBMIT   = 3'd0,
      FUNC_TICK     = 3'd1,
      FUNC_DRAIN    = 3'd2,
      FUNC_COMPLETE = 3'd3,
      FUNC_RESPONSE = 3'd4,
      FUNC_RESET    = 3'd5
   } func_type;

   typedef enum logic [3:0] {
      ST_ACCEPTED = 4'd0,
      ST_REJECTED = 4'd1,
      ST_TIMEOUT  = 4'd2,
      ST_DISPATCH = 4'd3,
      ST_IDLE     = 4'd4,
      ST_DONE     = 4'd5,
      ST_REFUSED  = 4'd6,
      ST_RESPONSE = 4'd7,
      ST_RESET    = 4'd8,
      ST_TICK     = 4'd9
   } status_type;

   typedef enum logic [2:0] {
      RC_NONE     = 3'd0,
      RC_PRIORITY = 3'd1,
      RC_STALE    = 3'd2,
      RC_DUP      = 3'd3,
      RC_QFULL    = 3'd4,
      RC_TFULL    = 3'd5
   } cause_type;

   localparam logic [9:0] MILLI_PER_TOKEN = 10'd1000;
   localparam logic [15:0] RATE_RESET     = 16'd10;
   localparam logic [1:0] CSR_RATE        = 2'd0;

endpackage
`default_nettype wire

>>> rtl/rlpd_id_search.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rlpd_id_search: id table with sequential duplicate search
// Memory of seen ids; one compare per cycle over the filled entries.
// ----------------------------------------------------------------------------
module rlpd_id_search #(
   parameter int DEPTH = 64,
   parameter int AW    = 6,
   parameter int CW    = 7
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [30:0]   key,
   input  wire logic [CW-1:0] fill,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   output logic               done,
   output logic               found
);
   logic [30:0]   mem [DEPTH];
   logic [30:0]   rd_ff;
   logic [CW-1:0] idx_ff, idx_in;
   logic          run_ff, run_in;
   logic          cmp_ff, cmp_in;
   logic          found_ff, found_in;
   logic          done_ff, done_in;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= key;
      end
      rd_ff <= mem[idx_ff[AW-1:0]];
   end

   always_comb begin
      idx_in   = idx_ff;
      run_in   = run_ff;
      cmp_in   = 1'b0;
      found_in = found_ff;
      done_in  = 1'b0;
      if (start) begin
         idx_in   = '0;
         run_in   = 1'b1;
         found_in = 1'b0;
      end else begin
         if (cmp_ff && rd_ff == key) begin
            found_in = 1'b1;
         end
         if (run_ff) begin
            if (idx_ff >= fill || idx_ff >= CW'(DEPTH)) begin
               run_in  = 1'b0;
               done_in = 1'b1;
            end else begin
               cmp_in = 1'b1;
               idx_in = idx_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         run_ff   <= 1'b0;
         cmp_ff   <= 1'b0;
         found_ff <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         run_ff   <= run_in;
         cmp_ff   <= cmp_in;
         found_ff <= found_in;
         done_ff  <= done_in;
      end
   end

   // done rises in the same cycle that found takes in the last compare
   assign done  = done_ff;
   assign found = found_ff;

endmodule
`default_nettype wire

>>> rtl/rate_limited_priority_dispatcher_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rate_limited_priority_dispatcher_top: token bucket strict priority dispatcher
//
// Commands enter on req_* when start is high and busy is low. Each command
// gives one or two results on rsp_*, each valid for one cycle under
// rsp_valid; the receiver cannot stall them. rsp_last marks the final one.
// Submit searches the id table one entry per cycle over the filled entries, at
// most ID_TABLE_DEPTH of them. Tick, complete, response and reset act in the
// scan state; drain first gives any timeout result, then scans the queues one
// level per cycle. Every command with a result ends with a pending count pass
// of one cycle per priority level. Busy is high throughout; codes 6 and 7 are
// taken without raising busy and give no result. The user must write the
// rate_limit register over the APB-style csr_* port only while idle; the block
// does not enforce it. Reset empties queues and id table, sets generation 0,
// loads a full bucket of rate_limit*1000 milli-tokens; no clearing pass.
// ----------------------------------------------------------------------------
module rate_limited_priority_dispatcher_top #(
   parameter int PRIORITY_LEVELS = 4,
   parameter int QUEUE_DEPTH     = 16,
   parameter int ID_TABLE_DEPTH  = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [2:0]  req_func,
   input  wire logic [3:0]  req_priority_req,
   input  wire logic [30:0] req_request_id,
   input  wire logic [63:0] req_generation,
   input  wire logic [15:0] req_timeout_ms,
   input  wire logic        req_success,
   output logic             rsp_valid,
   output logic [3:0]       rsp_status,
   output logic [2:0]       rsp_reject_cause,
   output logic [30:0]      rsp_event_request_id,
   output logic             rsp_ok,
   output logic             rsp_busy_res,
   output logic [6:0]       rsp_pending_total,
   output logic             rsp_last,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [1:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import rlpd_pkg::*;

   localparam int PW   = (PRIORITY_LEVELS > 1) ? $clog2(PRIORITY_LEVELS) : 1;
   localparam int QW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCW  = $clog2(QUEUE_DEPTH + 1);
   localparam int TAW  = (ID_TABLE_DEPTH > 1) ? $clog2(ID_TABLE_DEPTH) : 1;
   localparam int TCW  = $clog2(ID_TABLE_DEPTH + 1);
   localparam int QSZ  = PRIORITY_LEVELS * QUEUE_DEPTH;
   localparam int QAW  = (QSZ > 1) ? $clog2(QSZ) : 1;
   localparam int SUMW = $clog2(QSZ + 1);

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_SEARCH = 7'b0000010,
      S_SCAN   = 7'b0000100,
      S_READ   = 7'b0001000,
      S_RES1   = 7'b0010000,
      S_RES2   = 7'b0100000,
      S_SUM    = 7'b1000000
   } state_type;

   state_type state_ff;

   logic [2:0]  func_ff;
   logic [3:0]  prio_ff;
   logic [30:0] id_ff;
   logic [63:0] gen_ff;
   logic [15:0] tmo_ff;
   logic        succ_ff;

   logic [15:0] rate_ff;
   logic [25:0] tok_ff;
   logic [QW-1:0]  head_ff  [PRIORITY_LEVELS];
   logic [QCW-1:0] count_ff [PRIORITY_LEVELS];
   logic [TCW-1:0] seen_ff;
   logic [63:0] cgen_ff;
   logic        fl_ff;
   logic [30:0] act_ff;
   logic [15:0] tl_ff;
   logic        good_ff;

   logic [46:0] qmem [QSZ];
   logic [46:0] qrd_ff;
   logic [PW-1:0] pidx_ff;
   logic        pfound_ff;
   logic [SUMW-1:0] sum_ff;

   // first result held, second result held
   logic [3:0]  r1st_ff, r2st_ff;
   logic [2:0]  r1c_ff;
   logic [30:0] r1id_ff, r2id_ff;
   logic        r1ok_ff, r2ok_ff, two_ff;

   logic        srch_start, srch_done, srch_found;
   logic [PW-1:0] psel;
   logic        sub_commit;

   assign psel = prio_ff[PW-1:0];
   assign busy = (state_ff != S_IDLE);
   wire accept = start && !busy;
   wire [25:0] cap = 26'(rate_ff * MILLI_PER_TOKEN);

   logic csr_wr;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == CSR_RATE) ? {16'd0, rate_ff} : 32'd0;

   assign srch_start = accept && req_func == FUNC_SUBMIT;

   rlpd_id_search #(.DEPTH(ID_TABLE_DEPTH), .AW(TAW), .CW(TCW)) u_search (
      .clock  (clock),
      .reset  (reset),
      .start  (srch_start),
      .key    (accept ? req_request_id : id_ff),
      .fill   (seen_ff),
      .wr_en  (sub_commit),
      .wr_addr(seen_ff[TAW-1:0]),
      .done   (srch_done),
      .found  (srch_found)
   );

   // submit decision
   cause_type cause;
   always_comb begin
      cause = RC_NONE;
      if ({1'b0, prio_ff} >= 5'(PRIORITY_LEVELS)) cause = RC_PRIORITY;
      else if (gen_ff != cgen_ff) cause = RC_STALE;
      else if (srch_found) cause = RC_DUP;
      else if (count_ff[psel] >= QCW'(QUEUE_DEPTH)) cause = RC_QFULL;
      else if (seen_ff >= TCW'(ID_TABLE_DEPTH)) cause = RC_TFULL;
   end
   assign sub_commit = (state_ff == S_SEARCH) && srch_done && cause == RC_NONE;

   logic [QW:0]  slot_sum;
   logic [QW-1:0] slot;
   assign slot_sum = {1'b0, head_ff[psel]} + (QW+1)'(count_ff[psel]);
   assign slot = (slot_sum >= (QW+1)'(QUEUE_DEPTH)) ?
                 QW'(slot_sum - (QW+1)'(QUEUE_DEPTH)) : slot_sum[QW-1:0];

   logic [QAW-1:0] waddr, raddr;
   assign waddr = QAW'(psel * QUEUE_DEPTH) + QAW'(slot);
   assign raddr = QAW'(pidx_ff * QUEUE_DEPTH) + QAW'(head_ff[pidx_ff]);

   always_ff @(posedge clock) begin
      if (sub_commit) begin
         qmem[waddr] <= {id_ff, tmo_ff};
      end
      qrd_ff <= qmem[raddr];
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff <= req_func;
         prio_ff <= req_priority_req;
         id_ff   <= req_request_id;
         gen_ff  <= req_generation;
         tmo_ff  <= req_timeout_ms;
         succ_ff <= req_success;
      end
   end

   logic match;
   assign match = fl_ff && id_ff == act_ff && gen_ff == cgen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rate_ff  <= RATE_RESET;
         tok_ff   <= 26'(RATE_RESET * MILLI_PER_TOKEN);
         for (int p = 0; p < PRIORITY_LEVELS; p++) begin
            head_ff[p]  <= '0;
            count_ff[p] <= '0;
         end
         seen_ff  <= '0;
         cgen_ff  <= '0;
         fl_ff    <= 1'b0;
         act_ff   <= '0;
         tl_ff    <= '0;
         good_ff  <= 1'b1;
         pidx_ff  <= '0;
         pfound_ff <= 1'b0;
         sum_ff   <= '0;
         two_ff   <= 1'b0;
      end else begin
         if (csr_wr && csr_paddr == CSR_RATE) begin
            rate_ff <= (csr_pwdata[15:0] == 16'd0) ? 16'd1 : csr_pwdata[15:0];
            if (tok_ff > 26'(((csr_pwdata[15:0] == 16'd0) ? 16'd1 : csr_pwdata[15:0])
                              * MILLI_PER_TOKEN))
               tok_ff <= 26'(((csr_pwdata[15:0] == 16'd0) ? 16'd1 : csr_pwdata[15:0])
                             * MILLI_PER_TOKEN);
         end
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  two_ff <= 1'b0;
                  r1c_ff <= RC_NONE;
                  case (req_func)
                     FUNC_SUBMIT: state_ff <= S_SEARCH;
                     FUNC_TICK, FUNC_DRAIN, FUNC_COMPLETE, FUNC_RESPONSE,
                     FUNC_RESET: state_ff <= S_SCAN;
                     default: state_ff <= S_IDLE;
                  endcase
                  pidx_ff   <= '0;
                  pfound_ff <= 1'b0;
               end
            end
            S_SEARCH: begin
               if (srch_done) begin
                  r1st_ff <= (cause == RC_NONE) ? ST_ACCEPTED : ST_REJECTED;
                  r1c_ff  <= cause;
                  r1id_ff <= id_ff;
                  r1ok_ff <= (cause == RC_NONE);
                  if (cause == RC_NONE) begin
                     count_ff[psel] <= count_ff[psel] + 1'b1;
                     seen_ff <= seen_ff + 1'b1;
                  end
                  pidx_ff  <= '0;
                  sum_ff   <= '0;
                  state_ff <= S_SUM;
               end
            end
            S_SCAN: begin
               case (func_ff)
                  FUNC_TICK: begin
                     tok_ff <= (tok_ff + 26'(rate_ff) > cap) ? cap :
                               tok_ff + 26'(rate_ff);
                     if (fl_ff && tl_ff != 16'd0) tl_ff <= tl_ff - 1'b1;
                     r1st_ff <= ST_TICK; r1id_ff <= id_ff; r1ok_ff <= 1'b1;
                     pidx_ff <= '0; sum_ff <= '0; state_ff <= S_SUM;
                  end
                  FUNC_COMPLETE: begin
                     if (match) fl_ff <= 1'b0;
                     r1st_ff <= match ? ST_DONE : ST_REFUSED;
                     r1id_ff <= id_ff; r1ok_ff <= match;
                     pidx_ff <= '0; sum_ff <= '0; state_ff <= S_SUM;
                  end
                  FUNC_RESPONSE: begin
                     if (match) good_ff <= good_ff && succ_ff;
                     r1st_ff <= ST_RESPONSE; r1id_ff <= id_ff;
                     r1ok_ff <= match && good_ff && succ_ff;
                     pidx_ff <= '0; sum_ff <= '0; state_ff <= S_SUM;
                  end
                  FUNC_RESET: begin
                     for (int p = 0; p < PRIORITY_LEVELS; p++) begin
                        head_ff[p]  <= '0;
                        count_ff[p] <= '0;
                     end
                     seen_ff <= '0; cgen_ff <= gen_ff; fl_ff <= 1'b0;
                     r1st_ff <= ST_RESET; r1id_ff <= id_ff; r1ok_ff <= 1'b1;
                     pidx_ff <= '0; sum_ff <= '0; state_ff <= S_SUM;
                  end
                  default: begin
                     // drain: timeout first, then scan queues one level a cycle
                     if (fl_ff && tl_ff == 16'd0 && !pfound_ff && pidx_ff == '0
                         && !two_ff) begin
                        fl_ff   <= 1'b0;
                        two_ff  <= 1'b1;
                        r1st_ff <= ST_TIMEOUT; r1id_ff <= act_ff; r1ok_ff <= 1'b0;
                     end else if (fl_ff || tok_ff < 26'(MILLI_PER_TOKEN)) begin
                        state_ff <= S_RES1;
                     end else if (count_ff[pidx_ff] != '0) begin
                        state_ff <= S_READ;
                     end else if (pidx_ff == PW'(PRIORITY_LEVELS - 1)) begin
                        state_ff <= S_RES1;
                     end else begin
                        pidx_ff <= pidx_ff + 1'b1;
                     end
                  end
               endcase
            end
            S_READ: begin
               pfound_ff <= 1'b1;
               state_ff  <= S_RES1;
            end
            S_RES1: begin
               if (pfound_ff) begin
                  act_ff <= qrd_ff[46:16];
                  tl_ff  <= qrd_ff[15:0];
                  head_ff[pidx_ff] <= (head_ff[pidx_ff] == QW'(QUEUE_DEPTH - 1)) ?
                                      '0 : head_ff[pidx_ff] + 1'b1;
                  count_ff[pidx_ff] <= count_ff[pidx_ff] - 1'b1;
                  good_ff <= 1'b1;
                  tok_ff  <= tok_ff - 26'(MILLI_PER_TOKEN);
                  fl_ff   <= 1'b1;
                  r2st_ff <= ST_DISPATCH; r2id_ff <= qrd_ff[46:16]; r2ok_ff <= 1'b1;
               end else begin
                  r2st_ff <= ST_IDLE; r2id_ff <= id_ff; r2ok_ff <= 1'b0;
               end
               if (!two_ff) begin
                  r1st_ff <= pfound_ff ? ST_DISPATCH : ST_IDLE;
                  r1id_ff <= pfound_ff ? qrd_ff[46:16] : id_ff;
                  r1ok_ff <= pfound_ff;
               end
               pidx_ff  <= '0;
               sum_ff   <= '0;
               state_ff <= S_SUM;
            end
            S_SUM: begin
               sum_ff <= sum_ff + SUMW'(count_ff[pidx_ff]);
               if (pidx_ff == PW'(PRIORITY_LEVELS - 1)) state_ff <= S_RES2;
               else pidx_ff <= pidx_ff + 1'b1;
            end
            S_RES2: begin
               if (two_ff) two_ff <= 1'b0;
               else state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   always_comb begin
      rsp_valid            = (state_ff == S_RES2);
      rsp_last             = !two_ff;
      rsp_status           = r1st_ff;
      rsp_reject_cause     = r1c_ff;
      rsp_event_request_id = r1id_ff;
      rsp_ok               = r1ok_ff;
      if (state_ff == S_RES2 && !two_ff && func_ff == FUNC_DRAIN && r1st_ff == ST_TIMEOUT)
      begin
         rsp_status           = r2st_ff;
         rsp_event_request_id = r2id_ff;
         rsp_ok               = r2ok_ff;
      end
      rsp_busy_res      = fl_ff;
      rsp_pending_total = (sum_ff > SUMW'(127)) ? 7'd127 : 7'(sum_ff);
   end

endmodule
`default_nettype wire

>>> rtl/rlpd_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rlpd_checker: port-level checks for the dispatcher
// Watches command, result and register ports over time.
// ----------------------------------------------------------------------------
module rlpd_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       busy,
   input wire logic       rsp_valid,
   input wire logic       rsp_last,
   input wire logic [2:0] rsp_reject_cause,
   input wire logic [3:0] rsp_status,
   input wire logic       csr_pready
);
   import rlpd_pkg::*;

   a_second_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |=> rsp_valid && rsp_last)
      else $error("first result not followed by last");
   a_rsp_only_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("result while idle");
   a_cause_rejected: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_reject_cause != RC_NONE |-> rsp_status == ST_REJECTED)
      else $error("cause on non-reject");
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |=> !rsp_valid) else $error("result after last");
   a_pready: assert property (@(posedge clock) csr_pready)
      else $error("pready low");

endmodule

bind rate_limited_priority_dispatcher_top rlpd_checker u_rlpd_checker (
   .clock(clock), .reset(reset), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_last(rsp_last),
   .rsp_reject_cause(rsp_reject_cause), .rsp_status(rsp_status),
   .csr_pready(csr_pready)
);
`default_nettype wire

>>> verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: rate limited priority dispatcher
// A queued command driver and a result monitor around the dispatcher. Each
// accepted command is run through a local model of the queues, id table,
// token bucket and in-flight request; every result transfer is checked field
// by field against the oldest predicted event. A short directed part covers
// priority, stale and duplicate rejects, timeout, refusal and reset, then
// random sessions follow across several rate_limit settings.
// ----------------------------------------------------------------------------
module testbench;
   import rlpd_pkg::*;

   localparam int PL = 4;
   localparam int QD = 16;
   localparam int TD = 64;

   typedef struct {
      bit          is_cfg;
      bit          hold;
      logic [2:0]  func;
      logic [3:0]  prio;
      logic [30:0] id;
      logic [63:0] gen;
      logic [15:0] tmo;
      logic        succ;
      logic [31:0] cfg;
   } cmd_type;

   typedef struct {
      logic [3:0]  status;
      logic [2:0]  cause;
      logic [30:0] id;
      logic        ok;
      logic        busy;
      logic [6:0]  pend;
      logic        last;
   } event_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic rsp_valid, rsp_ok, rsp_busy_res, rsp_last;
   logic [3:0] rsp_status;
   logic [2:0] rsp_reject_cause;
   logic [30:0] rsp_event_request_id;
   logic [6:0] rsp_pending_total;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [1:0] csr_paddr = CSR_RATE;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   cmd_type cur = '{default: '0};
   cmd_type pending_cmds[$];
   event_type expected_events[$];
   int errors = 0;
   logic took = 1'b0;
   int quiet = 0;
   int gap_left = 0;
   int cfg_phase = 0;
   logic [31:0] cfg_val;

   // model state
   int unsigned rate, tokens;
   logic [30:0] q_id[PL][QD];
   logic [15:0] q_tmo[PL][QD];
   int heads[PL], counts[PL];
   logic [30:0] seen[TD];
   int seen_n;
   logic [63:0] cur_gen;
   bit in_flight, resp_good;
   logic [30:0] active_id;
   int unsigned time_left;

   always #5 clock = ~clock;

   rate_limited_priority_dispatcher_top #(
      .PRIORITY_LEVELS(PL), .QUEUE_DEPTH(QD), .ID_TABLE_DEPTH(TD)
   ) DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_func(cur.func), .req_priority_req(cur.prio), .req_request_id(cur.id),
      .req_generation(cur.gen), .req_timeout_ms(cur.tmo), .req_success(cur.succ),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status),
      .rsp_reject_cause(rsp_reject_cause), .rsp_event_request_id(rsp_event_request_id),
      .rsp_ok(rsp_ok), .rsp_busy_res(rsp_busy_res), .rsp_pending_total(rsp_pending_total),
      .rsp_last(rsp_last),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   task automatic apply_rate(input logic [31:0] v);
      rate = (v[15:0] == 0) ? 1 : v[15:0];
      if (tokens > rate * 1000) tokens = rate * 1000;
   endtask

   function automatic cause_type check_submit(input cmd_type c);
      int slot;
      if (c.prio >= PL) return RC_PRIORITY;
      if (c.gen != cur_gen) return RC_STALE;
      for (int i = 0; i < seen_n; i++)
         if (seen[i] == c.id) return RC_DUP;
      if (counts[c.prio] >= QD) return RC_QFULL;
      if (seen_n >= TD) return RC_TFULL;
      slot = (heads[c.prio] + counts[c.prio]) % QD;
      q_id[c.prio][slot] = c.id;
      q_tmo[c.prio][slot] = c.tmo;
      counts[c.prio]++;
      seen[seen_n++] = c.id;
      return RC_NONE;
   endfunction

   task automatic predict_events(input cmd_type c);
      event_type ev[2];
      int n;
      int tot;
      cause_type rc;
      bit sent, m;
      n = 0;
      sent = 0;
      case (c.func)
         FUNC_SUBMIT: begin
            rc = check_submit(c);
            ev[n++] = '{(rc == RC_NONE) ? ST_ACCEPTED : ST_REJECTED, rc, c.id,
                        rc == RC_NONE, 0, 0, 0};
         end
         FUNC_TICK: begin
            tokens = tokens + rate;
            if (tokens > rate * 1000) tokens = rate * 1000;
            if (in_flight && time_left > 0) time_left--;
            ev[n++] = '{ST_TICK, RC_NONE, c.id, 1, 0, 0, 0};
         end
         FUNC_DRAIN: begin
            if (in_flight && time_left == 0) begin
               in_flight = 0;
               ev[n++] = '{ST_TIMEOUT, RC_NONE, active_id, 0, 0, 0, 0};
            end
            if (!in_flight && tokens >= 1000) begin
               for (int p = 0; p < PL && !sent; p++) begin
                  if (counts[p] != 0) begin
                     active_id = q_id[p][heads[p]];
                     time_left = q_tmo[p][heads[p]];
                     heads[p] = (heads[p] + 1) % QD;
                     counts[p]--;
                     resp_good = 1;
                     tokens -= 1000;
                     in_flight = 1;
                     sent = 1;
                     ev[n++] = '{ST_DISPATCH, RC_NONE, active_id, 1, 0, 0, 0};
                  end
               end
            end
            if (!sent) ev[n++] = '{ST_IDLE, RC_NONE, c.id, 0, 0, 0, 0};
         end
         FUNC_COMPLETE: begin
            m = in_flight && c.id == active_id && c.gen == cur_gen;
            if (m) in_flight = 0;
            ev[n++] = '{m ? ST_DONE : ST_REFUSED, RC_NONE, c.id, m, 0, 0, 0};
         end
         FUNC_RESPONSE: begin
            m = in_flight && c.id == active_id && c.gen == cur_gen;
            if (m) resp_good = resp_good && c.succ;
            ev[n++] = '{ST_RESPONSE, RC_NONE, c.id, m && resp_good, 0, 0, 0};
         end
         FUNC_RESET: begin
            for (int p = 0; p < PL; p++) begin
               heads[p] = 0;
               counts[p] = 0;
            end
            seen_n = 0;
            cur_gen = c.gen;
            in_flight = 0;
            ev[n++] = '{ST_RESET, RC_NONE, c.id, 1, 0, 0, 0};
         end
         default: ;
      endcase
      tot = 0;
      for (int p = 0; p < PL; p++) tot += counts[p];
      if (tot > 127) tot = 127;
      for (int k = 0; k < n; k++) begin
         ev[k].busy = in_flight;
         ev[k].pend = 7'(tot);
         ev[k].last = (k == n - 1);
         expected_events.push_back(ev[k]);
      end
   endtask

   // acceptance and result checking
   always @(posedge clock) begin
      event_type e;
      if (!reset) begin
         if (start && !busy) predict_events(cur);
         took <= start && !busy;
         if (rsp_valid) begin
            if (expected_events.size() == 0) begin
               errors++;
               $display("%t unexpected result: status=%0d id=%0h", $time,
                        rsp_status, rsp_event_request_id);
            end else begin
               e = expected_events.pop_front();
               if (e.status !== rsp_status || e.cause !== rsp_reject_cause ||
                   e.id !== rsp_event_request_id || e.ok !== rsp_ok ||
                   e.busy !== rsp_busy_res || e.pend !== rsp_pending_total ||
                   e.last !== rsp_last) begin
                  errors++;
                  $display("%t mismatch exp st=%0d rc=%0d id=%0h ok=%0d b=%0d p=%0d l=%0d",
                           $time, e.status, e.cause, e.id, e.ok, e.busy, e.pend, e.last);
                  $display("%t          act st=%0d rc=%0d id=%0h ok=%0d b=%0d p=%0d l=%0d",
                           $time, rsp_status, rsp_reject_cause, rsp_event_request_id,
                           rsp_ok, rsp_busy_res, rsp_pending_total, rsp_last);
               end
            end
         end
         quiet <= (expected_events.size() == 0 && !busy && !start) ? quiet + 1 : 0;
      end
   end

   // command and register driver
   always @(negedge clock) begin
      logic nxt;
      bit idle;
      cmd_type h;
      if (!reset) begin
         nxt = start;
         if (took) nxt = 1'b0;
         if (cfg_phase == 1) begin
            csr_penable <= 1'b1;
            cfg_phase <= 2;
         end else if (cfg_phase == 2) begin
            csr_psel <= 1'b0;
            csr_penable <= 1'b0;
            csr_pwrite <= 1'b0;
            apply_rate(cfg_val);
            cfg_phase <= 0;
         end else if (!nxt) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
            end else if (pending_cmds.size() > 0) begin
               h = pending_cmds[0];
               idle = expected_events.size() == 0 && quiet >= 80 && !busy;
               if (h.is_cfg) begin
                  if (idle) begin
                     void'(pending_cmds.pop_front());
                     csr_psel <= 1'b1;
                     csr_pwrite <= 1'b1;
                     csr_paddr <= CSR_RATE;
                     csr_pwdata <= h.cfg;
                     cfg_val = h.cfg;
                     cfg_phase <= 1;
                  end
               end else if (!h.hold || idle) begin
                  void'(pending_cmds.pop_front());
                  cur <= h;
                  nxt = 1'b1;
                  if (pending_cmds.size() > 200 && $urandom_range(0, 3) == 0)
                     gap_left <= $urandom_range(1, 17);
                  else
                     gap_left <= 0;
               end
            end
         end
         start <= nxt;
      end
   end

   function automatic cmd_type mk(input logic [2:0] f, input logic [3:0] p,
                                  input logic [30:0] id, input logic [63:0] g,
                                  input logic [15:0] t, input logic s);
      cmd_type c;
      c = '{default: '0};
      c.func = f;
      c.prio = p;
      c.id = id;
      c.gen = g;
      c.tmo = t;
      c.succ = s;
      return c;
   endfunction

   function automatic cmd_type mk_cfg(input logic [15:0] v);
      cmd_type c;
      c = '{default: '0};
      c.is_cfg = 1;
      c.cfg = {16'($urandom_range(0, 16'hFFFF)), v};
      return c;
   endfunction

   function automatic logic [63:0] rand_gen();
      case ($urandom_range(0, 3))
         0: return '0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   initial begin
      logic [63:0] sess_gen;
      logic [30:0] used[$];
      logic [15:0] rates[7];
      cmd_type c;
      int r;

      rate = RATE_RESET;
      tokens = rate * 1000;
      for (int p = 0; p < PL; p++) begin
         heads[p] = 0;
         counts[p] = 0;
      end
      seen_n = 0;
      cur_gen = '0;
      in_flight = 0;
      resp_good = 1;
      active_id = '0;
      time_left = 0;

      pending_cmds.push_back(mk_cfg(RATE_RESET));
      pending_cmds.push_back(mk(FUNC_SUBMIT, 4'd15, 31'd1, '0, 16'd1, 1'b1));
      pending_cmds.push_back(mk(FUNC_SUBMIT, 4'd4, 31'd1, '0, 16'd1, 1'b0));
      pending_cmds.push_back(mk(FUNC_SUBMIT, 4'd0, 31'd1, 64'd5, 16'd1, 1'b0));
      pending_cmds.push_back(mk(FUNC_SUBMIT, 4'd0, 31'd0, '0, 16'd0, 1'b0));
      pending_cmds.push_back(mk(FUNC_SUBMIT, 4'd1, 31'd0, '0, 16'd3, 1'b0));
      pending_cmds.push_back(mk(FUNC_SUBMIT, 4'd3, 31'h7FFFFFFF, '0, 16'hFFFF, 1'b1));
      pending_cmds.push_back(mk(FUNC_TICK, 4'hF, 31'h7FFFFFFF, '1, 16'hFFFF, 1'b1));
      pending_cmds.push_back(mk(FUNC_DRAIN, 4'hF, 31'd9, '1, 16'hFFFF, 1'b1));
      pending_cmds.push_back(mk(FUNC_DRAIN, 4'd0, 31'd9, '0, 16'd0, 1'b0));
      pending_cmds.push_back(mk(FUNC_COMPLETE, 4'd0, 31'd5, '0, 16'd0, 1'b0));
      pending_cmds.push_back(mk(FUNC_RESPONSE, 4'd0, 31'h7FFFFFFF, '1, 16'd0, 1'b1));
      pending_cmds.push_back(mk(FUNC_RESPONSE, 4'd0, 31'h7FFFFFFF, '0, 16'd0, 1'b0));
      pending_cmds.push_back(mk(FUNC_RESPONSE, 4'd0, 31'h7FFFFFFF, '0, 16'd0, 1'b1));
      pending_cmds.push_back(mk(FUNC_COMPLETE, 4'd0, 31'h7FFFFFFF, '0, 16'd0, 1'b0));
      pending_cmds.push_back(mk(FUNC_COMPLETE, 4'd0, 31'h7FFFFFFF, '0, 16'd0, 1'b0));
      pending_cmds.push_back(mk(FUNC_DRAIN, 4'd0, 31'd3, '0, 16'd0, 1'b0));
      pending_cmds.push_back(mk(3'd6, 4'd0, 31'd3, '0, 16'd0, 1'b0));
      pending_cmds.push_back(mk(3'd7, 4'd0, 31'd3, '0, 16'd0, 1'b0));
      pending_cmds.push_back(mk(FUNC_RESET, 4'd0, 31'd4, '1, 16'd0, 1'b0));
      pending_cmds.push_back(mk(FUNC_SUBMIT, 4'd2, 31'd8, '0, 16'd2, 1'b0));
      pending_cmds.push_back(mk(FUNC_SUBMIT, 4'd2, 31'd8, '1, 16'd2, 1'b0));
      c = mk(FUNC_DRAIN, 4'd0, 31'd0, '1, 16'd0, 1'b0);
      c.hold = 1;
      pending_cmds.push_back(c);
      pending_cmds.push_back(mk(FUNC_COMPLETE, 4'd0, 31'd8, '1, 16'd0, 1'b0));

      rates = '{16'hFFFF, 16'd1, 16'd0, 16'd1000, 16'd10, 16'd0, 16'hFFFF};
      rates[5] = 16'($urandom_range(1, 16'hFFFF));
      sess_gen = '1;
      for (int ph = 0; ph < 7; ph++) begin
         pending_cmds.push_back(mk_cfg(rates[ph]));
         for (int i = 0; i < 190; i++) begin
            c = mk(3'($urandom_range(0, 5)), 4'($urandom), 31'($urandom),
                   {$urandom, $urandom}, 16'($urandom), 1'($urandom));
            c.hold = ($urandom_range(0, 99) == 0);
            r = $urandom_range(0, 99);
            if (r < 1) begin
               c.func = FUNC_RESET;
               sess_gen = rand_gen();
               c.gen = sess_gen;
               used.delete();
            end else if (r < 45) begin
               c.func = FUNC_SUBMIT;
               if ($urandom_range(0, 9) == 0) c.prio = 4'($urandom_range(0, 15));
               else if ($urandom_range(0, 1)) c.prio = 3;
               else c.prio = 4'($urandom_range(0, 3));
               if (used.size() > 0 && $urandom_range(0, 6) == 0)
                  c.id = used[$urandom_range(0, used.size() - 1)];
               else if ($urandom_range(0, 19) == 0)
                  c.id = $urandom_range(0, 1) ? 31'h7FFFFFFF : 31'd0;
               if ($urandom_range(0, 11) != 0) c.gen = sess_gen;
               if ($urandom_range(0, 4) != 0) c.tmo = 16'($urandom_range(0, 8));
               used.push_back(c.id);
            end else if (r < 62) begin
               c.func = FUNC_TICK;
            end else if (r < 80) begin
               c.func = FUNC_DRAIN;
            end else if (r < 98) begin
               c.func = (r < 90) ? FUNC_COMPLETE : FUNC_RESPONSE;
               if (used.size() > 0 && $urandom_range(0, 4) != 0)
                  c.id = used[$urandom_range(0, used.size() - 1)];
               if ($urandom_range(0, 9) != 0) c.gen = sess_gen;
            end else begin
               c.func = 3'($urandom_range(6, 7));
            end
            pending_cmds.push_back(c);
         end
      end

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (pending_cmds.size() != 0 || start || cfg_phase != 0 ||
             expected_events.size() != 0)
         @(posedge clock);
      repeat (100) @(posedge clock);
      if (expected_events.size() != 0) errors++;
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("FAIL");
      $finish;
   end

endmodule

>>> files.f
rtl/rlpd_pkg.sv
rtl/rlpd_id_search.sv
rtl/rate_limited_priority_dispatcher_top.sv
rtl/rlpd_checker.sv
verif/testbench.sv
